// ----- hw/rtl/rfir_pkg.sv -----
package rfir_pkg;

   localparam int FRAME_IDS = 256;
   localparam int FID_W     = 8;
   localparam int FCNT_W    = $clog2(FRAME_IDS + 1);

   // action codes
   localparam logic [1:0] ACT_SEND  = 2'd0;
   localparam logic [1:0] ACT_RADIO = 2'd1;
   localparam logic [1:0] ACT_DISC  = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DROP = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_DISC = 2'd3;

   // packet types
   localparam logic [7:0] PT_TX64     = 8'h00;
   localparam logic [7:0] PT_REMOTE   = 8'h17;
   localparam logic [7:0] PT_AT       = 8'h08;
   localparam logic [7:0] PT_AT_QUEUE = 8'h09;
   localparam logic [7:0] PT_DISCARD  = 8'h01;
   localparam logic [7:0] PT_RX64     = 8'h80;
   localparam logic [7:0] PT_AT_RSP   = 8'h88;
   localparam logic [7:0] PT_TX_STAT  = 8'h89;
   localparam logic [7:0] PT_REM_RSP  = 8'h97;

   localparam logic [7:0] GID_LAST = 8'd255;

   typedef enum logic {
      MODE_FIND = 1'b0,
      MODE_DISC = 1'b1
   } addr_mode_type;

   typedef struct packed {
      logic          start;
      addr_mode_type mode;
      logic          commit;
      logic [2:0]    client;
   } addr_cmd_type;

   typedef struct packed {
      logic       busy;
      logic       hit;
      logic [2:0] hit_owner;
      logic       full;
   } addr_stat_type;

   typedef struct packed {
      logic             lookup;
      logic             alloc;
      logic             disc_start;
      logic [FID_W-1:0] idx;
      logic [2:0]       client;
      logic [7:0]       local_id;
   } frame_cmd_type;

   typedef struct packed {
      logic       busy;
      logic       valid;
      logic [2:0] owner;
      logic [7:0] local_id;
   } frame_stat_type;

   function automatic logic is_claim(input logic [7:0] ptype);
      return (ptype == PT_TX64) || (ptype == PT_REMOTE);
   endfunction

   function automatic logic is_alloc(input logic [7:0] ptype);
      return (ptype == PT_TX64) || (ptype == PT_REMOTE) ||
             (ptype == PT_AT) || (ptype == PT_AT_QUEUE);
   endfunction

   function automatic logic is_frame_route(input logic [7:0] ptype);
      return (ptype == PT_AT_RSP) || (ptype == PT_TX_STAT) || (ptype == PT_REM_RSP);
   endfunction

endpackage

// ----- hw/rtl/rfir_frame_tbl.sv -----
module rfir_frame_tbl (
   input  logic                     clock,
   input  logic                     reset,
   input  rfir_pkg::frame_cmd_type  cmd,
   output rfir_pkg::frame_stat_type stat
);

   typedef struct packed {
      logic [2:0] owner;
      logic [7:0] local_id;
   } fentry_type;

   fentry_type mem [rfir_pkg::FRAME_IDS];
   fentry_type rd_ff;

   logic [rfir_pkg::FRAME_IDS-1:0] valid_ff;
   logic [rfir_pkg::FCNT_W-1:0]    cnt_ff;
   logic                           scan_ff;
   logic                           pend_ff;
   logic [rfir_pkg::FID_W-1:0]     idx_ff;

   logic                           rd_en;
   logic [rfir_pkg::FID_W-1:0]     rd_idx;
   logic                           scan_rd;
   logic                           cur_valid;

   assign scan_rd   = scan_ff && (cnt_ff < rfir_pkg::FCNT_W'(rfir_pkg::FRAME_IDS));
   assign rd_en     = scan_ff ? scan_rd : cmd.lookup;
   assign rd_idx    = scan_ff ? cnt_ff[rfir_pkg::FID_W-1:0] : cmd.idx;
   assign cur_valid = valid_ff[idx_ff];

   always_ff @(posedge clock) begin
      if (cmd.alloc) begin
         mem[cmd.idx] <= '{owner: cmd.client, local_id: cmd.local_id};
      end
      if (rd_en) begin
         rd_ff  <= mem[rd_idx];
         idx_ff <= rd_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         cnt_ff   <= '0;
         scan_ff  <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         if (cmd.disc_start) begin
            scan_ff <= 1'b1;
            cnt_ff  <= '0;
            pend_ff <= 1'b0;
         end else if (scan_ff) begin
            pend_ff <= scan_rd;
            if (scan_rd) begin
               cnt_ff <= cnt_ff + 1'b1;
            end
            if (!scan_rd && !pend_ff) begin
               scan_ff <= 1'b0;
            end
            // entry read last cycle: drop it if it belongs to the leaving client
            if (pend_ff && cur_valid && (rd_ff.owner == cmd.client)) begin
               valid_ff[idx_ff] <= 1'b0;
            end
         end
         if (cmd.alloc) begin
            valid_ff[cmd.idx] <= 1'b1;
         end
      end
   end

   assign stat.busy     = scan_ff;
   assign stat.valid    = cur_valid;
   assign stat.owner    = rd_ff.owner;
   assign stat.local_id = cur_valid ? rd_ff.local_id : 8'd0;

endmodule

// ----- hw/rtl/rfir_addr_tbl.sv -----
module rfir_addr_tbl #(
   parameter int ADDR_ENTRIES = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rfir_pkg::addr_cmd_type  cmd,
   input  logic [63:0]             key,
   output rfir_pkg::addr_stat_type stat
);

   localparam int AW = $clog2(ADDR_ENTRIES);
   localparam int CW = $clog2(ADDR_ENTRIES + 1);

   typedef struct packed {
      logic [63:0] key;
      logic [2:0]  owner;
   } aentry_type;

   aentry_type mem [ADDR_ENTRIES];
   aentry_type rd_ff;

   logic [ADDR_ENTRIES-1:0] valid_ff;
   logic [CW-1:0]           cnt_ff;
   logic                    scan_ff;
   logic                    pend_ff;
   rfir_pkg::addr_mode_type mode_ff;
   logic [AW-1:0]           idx_ff;
   logic                    hit_ff;
   logic                    free_ff;
   logic [AW-1:0]           hit_idx_ff;
   logic [AW-1:0]           free_idx_ff;
   logic [2:0]              hit_owner_ff;

   logic                    rd_en;
   logic                    cur_valid;
   logic                    wr_en;
   logic [AW-1:0]           wr_idx;

   assign rd_en     = scan_ff && (cnt_ff < CW'(ADDR_ENTRIES));
   assign cur_valid = valid_ff[idx_ff];
   assign wr_en     = cmd.commit && (hit_ff || free_ff);
   assign wr_idx    = hit_ff ? hit_idx_ff : free_idx_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         // a hit rewrites the same key, only the owner changes
         mem[wr_idx] <= '{key: key, owner: cmd.client};
      end
      if (rd_en) begin
         rd_ff  <= mem[cnt_ff[AW-1:0]];
         idx_ff <= cnt_ff[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         cnt_ff   <= '0;
         scan_ff  <= 1'b0;
         pend_ff  <= 1'b0;
         hit_ff   <= 1'b0;
         free_ff  <= 1'b0;
         mode_ff  <= rfir_pkg::MODE_FIND;
      end else begin
         if (cmd.start) begin
            scan_ff <= 1'b1;
            cnt_ff  <= '0;
            pend_ff <= 1'b0;
            hit_ff  <= 1'b0;
            free_ff <= 1'b0;
            mode_ff <= cmd.mode;
         end else if (scan_ff) begin
            pend_ff <= rd_en;
            if (rd_en) begin
               cnt_ff <= cnt_ff + 1'b1;
            end
            if (!rd_en && !pend_ff) begin
               scan_ff <= 1'b0;
            end
            if (pend_ff) begin
               if (mode_ff == rfir_pkg::MODE_FIND) begin
                  if (cur_valid && (rd_ff.key == key) && !hit_ff) begin
                     hit_ff       <= 1'b1;
                     hit_idx_ff   <= idx_ff;
                     hit_owner_ff <= rd_ff.owner;
                  end
                  // lowest empty slot
                  if (!cur_valid && !free_ff) begin
                     free_ff     <= 1'b1;
                     free_idx_ff <= idx_ff;
                  end
               end else if (cur_valid && (rd_ff.owner == cmd.client)) begin
                  valid_ff[idx_ff] <= 1'b0;
               end
            end
         end
         if (wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
      end
   end

   assign stat.busy      = scan_ff;
   assign stat.hit       = hit_ff;
   assign stat.hit_owner = hit_owner_ff;
   assign stat.full      = !hit_ff && !free_ff;

endmodule

// ----- hw/rtl/radio_frame_id_router_top.sv -----
// Frame-ID and address router between CLIENTS clients and one shared radio. One word in,
// one word out, one item at a time; a finished result waits in the output register while
// the next word is taken. Plain forwards, drops and undefined actions read no table.
// Frame-routed radio packets (0x88, 0x89, 0x97) wait for one read of the frame-ID
// memory. Address claims (0x00, 0x17) and source-address routing (0x80) wait for the
// scan of the address memory at one entry a cycle.
// A disconnect waits for the scan of the 256-entry frame-ID memory;
// the address memory is scanned alongside it. No clearing pass runs after reset.
module radio_frame_id_router_top #(
   parameter int CLIENTS      = 8,
   parameter int ADDR_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [2:0]  req_client_id,
   input  logic [7:0]  req_packet_type,
   input  logic [7:0]  req_frame_id,
   input  logic [63:0] req_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_out_frame_id,
   output logic [2:0]  rsp_deliver_client,
   output logic        rsp_broadcast
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_FRD  = 4'b0010,
      S_SCAN = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]  action_ff;
   logic [2:0]  client_ff;
   logic [7:0]  ptype_ff;
   logic [7:0]  fid_ff;
   logic [63:0] addr_ff;
   logic [7:0]  gid_ff, gid_in;

   logic        rsp_valid_ff;
   logic [1:0]  status_ff;
   logic [7:0]  ofid_ff;
   logic [2:0]  dclient_ff;
   logic        bcast_ff;

   logic [1:0]  status_in;
   logic [7:0]  ofid_in;
   logic [2:0]  dclient_in;
   logic        bcast_in;

   logic        accept;
   logic        in_client_ok, in_send_ok, in_addr_start, in_disc, in_lookup;
   logic        client_ok, send_ok, do_claim, do_alloc, done_fire;

   rfir_pkg::addr_cmd_type   acmd;
   rfir_pkg::addr_stat_type  astat;
   rfir_pkg::frame_cmd_type  fcmd;
   rfir_pkg::frame_stat_type fstat;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   assign in_client_ok  = ({29'd0, req_client_id} < 32'(CLIENTS));
   assign in_send_ok    = (req_action == rfir_pkg::ACT_SEND) && in_client_ok &&
                          (req_packet_type != rfir_pkg::PT_DISCARD);
   assign in_disc       = (req_action == rfir_pkg::ACT_DISC) && in_client_ok;
   assign in_lookup     = (req_action == rfir_pkg::ACT_RADIO) &&
                          rfir_pkg::is_frame_route(req_packet_type);
   assign in_addr_start = (in_send_ok && rfir_pkg::is_claim(req_packet_type)) ||
                          ((req_action == rfir_pkg::ACT_RADIO) &&
                           (req_packet_type == rfir_pkg::PT_RX64)) ||
                          in_disc;

   assign client_ok = ({29'd0, client_ff} < 32'(CLIENTS));
   assign send_ok   = (action_ff == rfir_pkg::ACT_SEND) && client_ok &&
                      (ptype_ff != rfir_pkg::PT_DISCARD);
   assign do_claim  = send_ok && rfir_pkg::is_claim(ptype_ff);
   assign do_alloc  = send_ok && rfir_pkg::is_alloc(ptype_ff) && (fid_ff != 8'd0);
   assign done_fire = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   assign gid_in = ((gid_ff == rfir_pkg::GID_LAST) || (gid_ff == 8'd0)) ? 8'd1
                                                                       : gid_ff + 8'd1;

   always_comb begin
      acmd.start  = accept && in_addr_start;
      acmd.mode   = (req_action == rfir_pkg::ACT_DISC) ? rfir_pkg::MODE_DISC
                                                      : rfir_pkg::MODE_FIND;
      acmd.commit = done_fire && do_claim;
      acmd.client = client_ff;

      fcmd.lookup     = accept && in_lookup;
      fcmd.alloc      = done_fire && do_alloc;
      fcmd.disc_start = accept && in_disc;
      fcmd.idx        = (state_ff == S_IDLE) ? req_frame_id : gid_ff;
      fcmd.client     = client_ff;
      fcmd.local_id   = fid_ff;
   end

   rfir_addr_tbl #(
      .ADDR_ENTRIES(ADDR_ENTRIES)
   ) u_addr (
      .clock(clock),
      .reset(reset),
      .cmd  (acmd),
      .key  (addr_ff),
      .stat (astat)
   );

   rfir_frame_tbl u_frame (
      .clock(clock),
      .reset(reset),
      .cmd  (fcmd),
      .stat (fstat)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (in_addr_start) begin
                  state_in = S_SCAN;
               end else if (in_lookup) begin
                  state_in = S_FRD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_FRD: begin
            state_in = S_DONE;
         end
         S_SCAN: begin
            if (!astat.busy && !fstat.busy) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (done_fire) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      status_in  = rfir_pkg::ST_DROP;
      ofid_in    = 8'd0;
      dclient_in = 3'd0;
      bcast_in   = 1'b0;
      case (action_ff)
         rfir_pkg::ACT_SEND: begin
            if (send_ok) begin
               status_in = (do_claim && astat.full) ? rfir_pkg::ST_FULL : rfir_pkg::ST_OK;
               ofid_in   = do_alloc ? gid_ff : fid_ff;
            end
         end
         rfir_pkg::ACT_RADIO: begin
            status_in = rfir_pkg::ST_OK;
            ofid_in   = fid_ff;
            bcast_in  = 1'b1;
            if (ptype_ff == rfir_pkg::PT_RX64) begin
               if (astat.hit) begin
                  bcast_in   = 1'b0;
                  dclient_in = astat.hit_owner;
               end
            end else if (rfir_pkg::is_frame_route(ptype_ff)) begin
               ofid_in = fstat.local_id;
               if (fstat.valid) begin
                  bcast_in   = 1'b0;
                  dclient_in = fstat.owner;
               end
            end
         end
         rfir_pkg::ACT_DISC: begin
            status_in = rfir_pkg::ST_DISC;
         end
         default: begin
            status_in = rfir_pkg::ST_DROP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gid_ff       <= 8'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (fcmd.alloc) begin
            gid_ff <= gid_in;
         end
         if (done_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         client_ff <= req_client_id;
         ptype_ff  <= req_packet_type;
         fid_ff    <= req_frame_id;
         addr_ff   <= req_address;
      end
      if (done_fire) begin
         status_ff  <= status_in;
         ofid_ff    <= ofid_in;
         dclient_ff <= dclient_in;
         bcast_ff   <= bcast_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_out_frame_id   = ofid_ff;
   assign rsp_deliver_client = dclient_ff;
   assign rsp_broadcast      = bcast_ff;

endmodule

// ----- sim/radio_frame_id_router_checker.sv -----
module radio_frame_id_router_checker
   import rfir_pkg::*;
#(
   parameter int CLIENTS      = 8,
   parameter int ADDR_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [2:0]  req_client_id,
   input  logic [7:0]  req_packet_type,
   input  logic [7:0]  req_frame_id,
   input  logic [63:0] req_address,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_status,
   input  logic [7:0]  rsp_out_frame_id,
   input  logic [2:0]  rsp_deliver_client,
   input  logic        rsp_broadcast,
   output int          outstanding,
   output int          mismatches
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] frame_id;
      logic [2:0] client;
      logic       bcast;
   } route_type;

   // shadow of the routing tables
   logic        gid_live  [FRAME_IDS];
   logic [2:0]  gid_owner [FRAME_IDS];
   logic [7:0]  gid_local [FRAME_IDS];
   logic [63:0] addr_key   [ADDR_ENTRIES];
   logic [2:0]  addr_owner [ADDR_ENTRIES];
   logic        addr_live  [ADDR_ENTRIES];
   logic [7:0]  next_gid;

   route_type due_q[$];
   int        fails = 0;

   function automatic int find_slot(input logic [63:0] addr);
      for (int i = 0; i < ADDR_ENTRIES; i++)
         if (addr_live[i] && addr_key[i] == addr) return i;
      return -1;
   endfunction

   function automatic route_type route_word(input logic [1:0] act, input logic [2:0] cid,
                                            input logic [7:0] ptype, input logic [7:0] fid,
                                            input logic [63:0] addr);
      route_type  r;
      int         slot;
      logic       full;
      logic [7:0] gid;
      r = '{status: ST_DROP, frame_id: 8'd0, client: 3'd0, bcast: 1'b0};
      full = 1'b0;
      case (act)
         ACT_SEND: begin
            if (cid < CLIENTS && ptype != PT_DISCARD) begin
               r.status   = ST_OK;
               r.frame_id = fid;
               if (ptype == PT_TX64 || ptype == PT_REMOTE) begin
                  slot = find_slot(addr);
                  if (slot < 0) begin
                     for (int i = ADDR_ENTRIES - 1; i >= 0; i--)
                        if (!addr_live[i]) slot = i;
                     if (slot >= 0) begin
                        addr_live[slot] = 1'b1;
                        addr_key[slot]  = addr;
                     end
                  end
                  if (slot >= 0) addr_owner[slot] = cid;
                  else full = 1'b1;
               end
               if ((ptype == PT_TX64 || ptype == PT_REMOTE || ptype == PT_AT ||
                    ptype == PT_AT_QUEUE) && fid != 8'd0) begin
                  gid = next_gid;
                  next_gid = (gid >= GID_LAST || gid == 8'd0) ? 8'd1 : gid + 8'd1;
                  gid_live[gid]  = 1'b1;
                  gid_owner[gid] = cid;
                  gid_local[gid] = fid;
                  r.frame_id     = gid;
               end
               if (full) r.status = ST_FULL;
            end
         end
         ACT_RADIO: begin
            r.status   = ST_OK;
            r.frame_id = fid;
            r.bcast    = 1'b1;
            if (ptype == PT_RX64) begin
               slot = find_slot(addr);
               if (slot >= 0) begin
                  r.bcast  = 1'b0;
                  r.client = addr_owner[slot];
               end
            end else if (ptype == PT_AT_RSP || ptype == PT_TX_STAT || ptype == PT_REM_RSP) begin
               // global ID maps back to the sender's local ID, even when unowned
               r.frame_id = gid_local[fid];
               if (gid_live[fid]) begin
                  r.bcast  = 1'b0;
                  r.client = gid_owner[fid];
               end
            end
         end
         ACT_DISC: begin
            r.status = ST_DISC;
            if (cid < CLIENTS) begin
               for (int i = 0; i < FRAME_IDS; i++)
                  if (gid_live[i] && gid_owner[i] == cid) begin
                     gid_live[i]  = 1'b0;
                     gid_owner[i] = 3'd0;
                     gid_local[i] = 8'd0;
                  end
               for (int i = 0; i < ADDR_ENTRIES; i++)
                  if (addr_live[i] && addr_owner[i] == cid) begin
                     addr_live[i]  = 1'b0;
                     addr_owner[i] = 3'd0;
                  end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic check_field(input string label, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t %s: expected %0h, got %0h", $time, label, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin : watch
      route_type want;
      if (reset) begin
         for (int i = 0; i < FRAME_IDS; i++) begin
            gid_live[i]  = 1'b0;
            gid_owner[i] = 3'd0;
            gid_local[i] = 8'd0;
         end
         for (int i = 0; i < ADDR_ENTRIES; i++) begin
            addr_key[i]   = 64'd0;
            addr_owner[i] = 3'd0;
            addr_live[i]  = 1'b0;
         end
         next_gid = 8'd1;
         due_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_q.size() == 0) begin
               $display("%0t unexpected word: status %0h frame_id %0h client %0h bcast %0h",
                        $time, rsp_status, rsp_out_frame_id, rsp_deliver_client, rsp_broadcast);
               fails++;
            end else begin
               want = due_q.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("out_frame_id", 32'(want.frame_id), 32'(rsp_out_frame_id));
               check_field("deliver_client", 32'(want.client), 32'(rsp_deliver_client));
               check_field("broadcast", 32'(want.bcast), 32'(rsp_broadcast));
            end
         end
         if (req_valid && !req_stall)
            due_q.push_back(route_word(req_action, req_client_id, req_packet_type,
                                       req_frame_id, req_address));
      end
      outstanding <= due_q.size();
      mismatches  <= fails;
   end

endmodule

// ----- sim/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import rfir_pkg::*;

   localparam int CLIENTS        = 8;
   localparam int ADDR_ENTRIES   = 16;
   localparam int POOL           = 24;
   localparam int PHASE_ITEMS    = 275;
   localparam int HOLDOFF_CYCLES = 500;
   localparam int QUIET_LIMIT    = 5000;
   localparam int TAIL_CYCLES    = 300;

   localparam logic [1:0] ACT_NONE    = 2'd3;
   localparam logic [7:0] PT_UNLISTED = 8'h10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = '0;
   logic [2:0]  req_client_id = '0;
   logic [7:0]  req_packet_type = '0;
   logic [7:0]  req_frame_id = '0;
   logic [63:0] req_address = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_out_frame_id;
   logic [2:0]  rsp_deliver_client;
   logic        rsp_broadcast;

   int          outstanding;
   int          mismatches;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 30;
   int          holdoff_reqs = 0;
   int          holdoff_seen = 0;
   int          holdoff_left = 0;
   int          quiet_cycles = 0;
   logic [63:0] addr_pool [POOL];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   radio_frame_id_router_top #(
      .CLIENTS      (CLIENTS),
      .ADDR_ENTRIES (ADDR_ENTRIES)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_client_id      (req_client_id),
      .req_packet_type    (req_packet_type),
      .req_frame_id       (req_frame_id),
      .req_address        (req_address),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_out_frame_id   (rsp_out_frame_id),
      .rsp_deliver_client (rsp_deliver_client),
      .rsp_broadcast      (rsp_broadcast)
   );

   radio_frame_id_router_checker #(
      .CLIENTS      (CLIENTS),
      .ADDR_ENTRIES (ADDR_ENTRIES)
   ) route_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_client_id      (req_client_id),
      .req_packet_type    (req_packet_type),
      .req_frame_id       (req_frame_id),
      .req_address        (req_address),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_out_frame_id   (rsp_out_frame_id),
      .rsp_deliver_client (rsp_deliver_client),
      .rsp_broadcast      (rsp_broadcast),
      .outstanding        (outstanding),
      .mismatches         (mismatches)
   );

   // result side: random stall, or a long hold-off when asked for
   always @(posedge clock) begin
      if (holdoff_reqs != holdoff_seen) begin
         holdoff_seen = holdoff_reqs;
         holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_word(input logic [1:0] act, input logic [2:0] cid,
                            input logic [7:0] ptype, input logic [7:0] fid,
                            input logic [63:0] addr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_client_id   <= cid;
      req_packet_type <= ptype;
      req_frame_id    <= fid;
      req_address     <= addr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // sender holds off until every word in flight has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic random_word();
      int unsigned pick;
      logic [1:0]  act;
      logic [2:0]  cid;
      logic [7:0]  ptype;
      logic [7:0]  fid;
      logic [63:0] addr;
      pick  = $urandom_range(99);
      cid   = 3'($urandom_range(CLIENTS - 1));
      fid   = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(255));
      ptype = 8'($urandom_range(255));
      addr  = ($urandom_range(4) == 0) ? {$urandom, $urandom}
                                       : addr_pool[$urandom_range(POOL - 1)];
      if (pick < 50) begin
         act = ACT_SEND;
         case ($urandom_range(6))
            0: ptype = PT_TX64;
            1: ptype = PT_REMOTE;
            2: ptype = PT_AT;
            3: ptype = PT_AT_QUEUE;
            4: ptype = PT_DISCARD;
            default: ;
         endcase
      end else if (pick < 93) begin
         act = ACT_RADIO;
         case ($urandom_range(4))
            0: ptype = PT_RX64;
            1: ptype = PT_AT_RSP;
            2: ptype = PT_TX_STAT;
            3: ptype = PT_REM_RSP;
            default: ;
         endcase
      end else if (pick < 97) begin
         act = ACT_DISC;
      end else begin
         act = ACT_NONE;
      end
      send_word(act, cid, ptype, fid, addr);
   endtask

   initial begin : stimulus
      logic [63:0] spare_addr;
      int          idle_plan [4];
      int          stall_plan [4];
      idle_plan  = '{0, 82, 0, 6};
      stall_plan = '{0, 0, 82, 6};
      for (int i = 0; i < POOL; i++) addr_pool[i] = {$urandom, $urandom};
      spare_addr = {$urandom, $urandom};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_word(ACT_SEND, 3'd0, PT_TX64, 8'h01, 64'h0);
      send_word(ACT_SEND, 3'd7, PT_REMOTE, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(ACT_SEND, 3'd3, PT_AT, 8'h80, spare_addr);
      send_word(ACT_SEND, 3'd5, PT_AT_QUEUE, 8'h7F, spare_addr);
      send_word(ACT_SEND, 3'd2, PT_TX64, 8'h00, spare_addr);          // no local frame ID
      send_word(ACT_SEND, 3'd1, PT_DISCARD, 8'h44, spare_addr);
      send_word(ACT_SEND, 3'd6, PT_UNLISTED, 8'h33, spare_addr);
      send_word(ACT_SEND, 3'd4, PT_REMOTE, 8'h00, 64'h0);             // address changes owner
      send_word(ACT_RADIO, 3'd0, PT_RX64, 8'h21, 64'h0);
      send_word(ACT_RADIO, 3'd0, PT_RX64, 8'h22, ~spare_addr);
      send_word(ACT_RADIO, 3'd0, PT_AT_RSP, 8'h01, 64'h0);
      send_word(ACT_RADIO, 3'd0, PT_TX_STAT, 8'h02, 64'h0);
      send_word(ACT_RADIO, 3'd0, PT_REM_RSP, 8'hC8, 64'h0);            // unowned global ID
      send_word(ACT_RADIO, 3'd0, PT_UNLISTED, 8'h5A, spare_addr);
      send_word(ACT_NONE, 3'd7, PT_TX64, 8'h11, spare_addr);
      send_word(ACT_DISC, 3'd7, 8'h00, 8'h00, 64'h0);
      send_word(ACT_RADIO, 3'd0, PT_TX_STAT, 8'h02, 64'h0);
      // fill the address table, then one more claim overflows it
      for (int i = 0; i < ADDR_ENTRIES - 1; i++)
         send_word(ACT_SEND, 3'(i), PT_TX64, 8'(i), {$urandom, $urandom});
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = idle_plan[phase];
         rsp_stall_pct <= stall_plan[phase];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 0 && n == 100) holdoff_reqs <= holdoff_reqs + 1;
            random_word();
         end
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
